### sv/tlkv_pkg.sv
`default_nettype none
package tlkv_pkg;

	// field widths of the channels
	localparam int OP_W       = 2;
	localparam int FIELD_W    = 64;
	localparam int TOTAL_W    = 32;
	localparam int CAP_W      = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PROMOTE  = CFG_IDX_W'(1);

	// tier codes
	localparam logic [1:0] TIER_MISS = 2'd0;
	localparam logic [1:0] TIER_FAST = 2'd1;
	localparam logic [1:0] TIER_SLOW = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_GET = 2'd0,
		OP_PUT = 2'd1,
		OP_DEL = 2'd2
	} tlkv_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FSCAN,
		ST_SSCAN,
		ST_ROOM,
		ST_LRU,
		ST_DRD,
		ST_SFREE,
		ST_FFREE,
		ST_DONE
	} tlkv_state_t;

	typedef enum logic [1:0] {
		RK_IDLE,
		RK_TOUCH,
		RK_REMOVE,
		RK_INSERT
	} tlkv_rank_op_t;

	typedef struct packed {
		tlkv_rank_op_t op;
		logic          mru;
	} tlkv_rank_ctl_t;

endpackage
`default_nettype wire

### sv/tlkv_if.sv
`default_nettype none
// request channel
interface tlkv_in_if;
	logic                          valid;
	logic                          ready;
	logic [tlkv_pkg::OP_W-1:0]     operation;
	logic [tlkv_pkg::FIELD_W-1:0]  key;
	logic [tlkv_pkg::FIELD_W-1:0]  write_value;
	modport source(output valid, operation, key, write_value, input ready);
	modport sink(input valid, operation, key, write_value, output ready);
endinterface

// response channel
interface tlkv_out_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [1:0]                    hit_tier;
	logic [tlkv_pkg::FIELD_W-1:0]  read_value;
	logic [tlkv_pkg::TOTAL_W-1:0]  fast_hit_total;
	logic [tlkv_pkg::TOTAL_W-1:0]  slow_hit_total;
	logic                          slow_overflow;
	modport source(output valid, found, hit_tier, read_value, fast_hit_total,
		slow_hit_total, slow_overflow, input ready);
	modport sink(input valid, found, hit_tier, read_value, fast_hit_total,
		slow_hit_total, slow_overflow, output ready);
endinterface

// configuration write channel
interface tlkv_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [tlkv_pkg::CFG_IDX_W-1:0]   index;
	logic [tlkv_pkg::CFG_DATA_W-1:0]  data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/tlkv_mem.sv
`default_nettype none
module tlkv_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 128
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### sv/tlkv_rank.sv
`default_nettype none
module tlkv_rank #(
	parameter int ENTRIES = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  tlkv_pkg::tlkv_rank_ctl_t                  ctl,
	input  logic [$clog2(ENTRIES)-1:0]                slot,
	output logic [ENTRIES-1:0]                        valid,
	output logic [ENTRIES-1:0][$clog2(ENTRIES)-1:0]   rank,
	output logic [$clog2(ENTRIES+1)-1:0]              count
);
	import tlkv_pkg::*;

	localparam int RW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	logic [ENTRIES-1:0]          valid_q;
	logic [ENTRIES-1:0][RW-1:0]  rank_q;
	logic [CW-1:0]               count_q;

	// update valid bits and recency ranks, 0 is most recent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rank_q  <= '0;
			count_q <= '0;
		end else begin
			case (ctl.op)
				RK_TOUCH: begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid_q[i] && rank_q[i] < rank_q[slot]) begin
							rank_q[i] <= rank_q[i] + RW'(1);
						end
					end
					rank_q[slot] <= '0;
				end
				RK_REMOVE: begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid_q[i] && rank_q[i] > rank_q[slot]) begin
							rank_q[i] <= rank_q[i] - RW'(1);
						end
					end
					valid_q[slot] <= 1'b0;
					count_q       <= count_q - CW'(1);
				end
				RK_INSERT: begin
					if (ctl.mru) begin
						for (int i = 0; i < ENTRIES; i++) begin
							if (valid_q[i]) begin
								rank_q[i] <= rank_q[i] + RW'(1);
							end
						end
						rank_q[slot] <= '0;
					end else begin
						rank_q[slot] <= count_q[RW-1:0];
					end
					valid_q[slot] <= 1'b1;
					count_q       <= count_q + CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	assign valid = valid_q;
	assign rank  = rank_q;
	assign count = count_q;
endmodule
`default_nettype wire

### sv/two_tier_lru_key_value_store.sv
// channel | dir | payload                                      | accepted when
// req     | in  | operation, key, write_value                  | valid & ready
// rsp     | out | found, hit_tier, read_value, totals, overflow | valid & ready
// cfg     | in  | index, data                                  | valid & ready
//
// One word at a time: one key comparator per tier steps through the fast tier,
// then the slow tier, one entry a cycle. Each demotion scans the fast ranks for
// the least recent entry, reads it and writes it to a free slow slot, and a
// fast-tier insertion scans for a free fast slot. req is ready only while
// idle; a held response stalls it.
// arst_n clears all valid bits at once; no clearing pass is needed.
`default_nettype none
module two_tier_lru_key_value_store #(
	parameter int FAST_ENTRIES = 16,
	parameter int SLOW_ENTRIES = 64,
	parameter int KEY_BITS     = 64,
	parameter int VALUE_BITS   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	tlkv_in_if.sink     req,
	tlkv_out_if.source  rsp,
	tlkv_cfg_if.sink    cfg
);
	import tlkv_pkg::*;

	localparam int FIW      = $clog2(FAST_ENTRIES);
	localparam int SIW      = $clog2(SLOW_ENTRIES);
	localparam int RW       = $clog2(FAST_ENTRIES);
	localparam int CW       = $clog2(FAST_ENTRIES + 1);
	localparam int SCAN_MAX = (FAST_ENTRIES > SLOW_ENTRIES) ? FAST_ENTRIES : SLOW_ENTRIES;
	localparam int SCW      = $clog2(SCAN_MAX + 1);
	localparam int EW       = KEY_BITS + VALUE_BITS;

	tlkv_state_t state_q, state_d;

	tlkv_op_t                op_q;
	logic [KEY_BITS-1:0]     key_q, dkey_q;
	logic [VALUE_BITS-1:0]   val_q, ins_val_q, rd_q, dval_q;
	logic                    ins_mru_q;
	logic [SCW-1:0]          scan_q, idx_s1;
	logic                    chk_s1;
	logic [FIW-1:0]          slot_q;
	logic                    found_q, ovf_q;
	logic [1:0]              tier_q;
	logic [TOTAL_W-1:0]      fast_hits_q, slow_hits_q;
	logic                    rsp_valid_q;
	logic [CAP_W-1:0]        cap_q;
	logic                    promote_q;
	logic [SLOW_ENTRIES-1:0] svalid_q;

	// fast tier ranks and valid bits
	tlkv_rank_ctl_t                rk_ctl;
	logic [FIW-1:0]                rk_slot;
	logic [FAST_ENTRIES-1:0]       fvalid;
	logic [FAST_ENTRIES-1:0][RW-1:0] frank;
	logic [CW-1:0]                 fcount;

	// entry memories, key over value
	logic           fm_we, sm_we;
	logic [FIW-1:0] fm_waddr, fm_raddr;
	logic [SIW-1:0] sm_waddr, sm_raddr;
	logic [EW-1:0]  fm_wdata, fm_rdata, sm_wdata, sm_rdata;

	logic [KEY_BITS-1:0]   f_key, s_key;
	logic [VALUE_BITS-1:0] f_val, s_val;
	logic                  fmatch, f_last, smatch, s_last;
	logic                  lru_hit, sfree, s_end, ffree, need_room, req_op_ok;
	logic [CW-1:0]         eff_cap;

	tlkv_rank #(.ENTRIES(FAST_ENTRIES)) u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rk_ctl),
		.slot   (rk_slot),
		.valid  (fvalid),
		.rank   (frank),
		.count  (fcount)
	);

	tlkv_mem #(.DEPTH(FAST_ENTRIES), .WIDTH(EW)) u_fast_mem (
		.clk   (clk),
		.we    (fm_we),
		.waddr (fm_waddr),
		.wdata (fm_wdata),
		.raddr (fm_raddr),
		.rdata (fm_rdata)
	);

	tlkv_mem #(.DEPTH(SLOW_ENTRIES), .WIDTH(EW)) u_slow_mem (
		.clk   (clk),
		.we    (sm_we),
		.waddr (sm_waddr),
		.wdata (sm_wdata),
		.raddr (sm_raddr),
		.rdata (sm_rdata)
	);

	// split read words and compare against the held key
	assign f_key  = fm_rdata[EW-1 -: KEY_BITS];
	assign f_val  = fm_rdata[VALUE_BITS-1:0];
	assign s_key  = sm_rdata[EW-1 -: KEY_BITS];
	assign s_val  = sm_rdata[VALUE_BITS-1:0];
	assign fmatch = chk_s1 && fvalid[idx_s1[FIW-1:0]] && (f_key == key_q);
	assign f_last = chk_s1 && (idx_s1 == SCW'(FAST_ENTRIES - 1));
	assign smatch = chk_s1 && svalid_q[idx_s1[SIW-1:0]] && (s_key == key_q);
	assign s_last = chk_s1 && (idx_s1 == SCW'(SLOW_ENTRIES - 1));

	assign lru_hit = fvalid[scan_q[FIW-1:0]] &&
		(CW'(frank[scan_q[FIW-1:0]]) == (fcount - CW'(1)));
	assign sfree   = !svalid_q[scan_q[SIW-1:0]];
	assign s_end   = (scan_q == SCW'(SLOW_ENTRIES - 1));
	assign ffree   = !fvalid[scan_q[FIW-1:0]];

	assign req_op_ok = (req.operation == OP_GET) || (req.operation == OP_PUT) ||
		(req.operation == OP_DEL);

	// clamp the capacity register to 1..FAST_ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (32'(cap_q) > FAST_ENTRIES) begin
			eff_cap = CW'(FAST_ENTRIES);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end
	assign need_room = (fcount >= eff_cap);

	// next state and strobes
	always_comb begin
		state_d  = state_q;
		rk_ctl   = '{op: RK_IDLE, mru: 1'b0};
		rk_slot  = slot_q;
		fm_we    = 1'b0;
		fm_waddr = slot_q;
		fm_wdata = {key_q, val_q};
		fm_raddr = scan_q[FIW-1:0];
		sm_we    = 1'b0;
		sm_waddr = scan_q[SIW-1:0];
		sm_wdata = {dkey_q, dval_q};
		sm_raddr = scan_q[SIW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = req_op_ok ? ST_FSCAN : ST_DONE;
				end
			end
			ST_FSCAN: begin
				if (fmatch) begin
					rk_slot = idx_s1[FIW-1:0];
					rk_ctl.op = (op_q == OP_DEL) ? RK_REMOVE : RK_TOUCH;
					if (op_q == OP_PUT) begin
						fm_we    = 1'b1;
						fm_waddr = idx_s1[FIW-1:0];
					end
					state_d = ST_DONE;
				end else if (f_last) begin
					state_d = ST_SSCAN;
				end
			end
			ST_SSCAN: begin
				if (smatch) begin
					if (op_q == OP_DEL) begin
						state_d = ST_DONE;
					end else if (promote_q) begin
						state_d = ST_ROOM;
					end else begin
						if (op_q == OP_PUT) begin
							sm_we    = 1'b1;
							sm_waddr = idx_s1[SIW-1:0];
							sm_wdata = {key_q, val_q};
						end
						state_d = ST_DONE;
					end
				end else if (s_last) begin
					state_d = (op_q == OP_PUT) ? ST_ROOM : ST_DONE;
				end
			end
			ST_ROOM: begin
				state_d = need_room ? ST_LRU : ST_FFREE;
			end
			ST_LRU: begin
				if (lru_hit) begin
					state_d = ST_DRD;
				end
			end
			ST_DRD: begin
				rk_ctl.op = RK_REMOVE;
				state_d   = ST_SFREE;
			end
			ST_SFREE: begin
				if (sfree) begin
					sm_we   = 1'b1;
					state_d = ST_ROOM;
				end else if (s_end) begin
					state_d = ST_ROOM;
				end
			end
			ST_FFREE: begin
				if (ffree) begin
					fm_we    = 1'b1;
					fm_waddr = scan_q[FIW-1:0];
					fm_wdata = {key_q, ins_val_q};
					rk_ctl   = '{op: RK_INSERT, mru: ins_mru_q};
					rk_slot  = scan_q[FIW-1:0];
					state_d  = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers: scan counter, slow valid bits, totals, config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			idx_s1      <= '0;
			chk_s1      <= 1'b0;
			svalid_q    <= '0;
			fast_hits_q <= '0;
			slow_hits_q <= '0;
			rsp_valid_q <= 1'b0;
			cap_q       <= CAP_W'(16);
			promote_q   <= 1'b1;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_CAPACITY: cap_q <= cfg.data[CAP_W-1:0];
					CFG_PROMOTE:  promote_q <= cfg.data[0];
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						scan_q <= '0;
						chk_s1 <= 1'b0;
						if (!req_op_ok) begin
							rsp_valid_q <= 1'b1;
						end
					end
				end
				ST_FSCAN: begin
					if (fmatch) begin
						if (op_q == OP_GET) begin
							fast_hits_q <= fast_hits_q + TOTAL_W'(1);
						end
						rsp_valid_q <= 1'b1;
					end else if (f_last) begin
						scan_q <= '0;
						chk_s1 <= 1'b0;
					end else begin
						chk_s1 <= 1'b1;
						idx_s1 <= scan_q;
						scan_q <= scan_q + SCW'(1);
					end
				end
				ST_SSCAN: begin
					if (smatch) begin
						if (op_q == OP_GET) begin
							slow_hits_q <= slow_hits_q + TOTAL_W'(1);
						end
						if (op_q == OP_DEL || promote_q) begin
							svalid_q[idx_s1[SIW-1:0]] <= 1'b0;
						end
						if (op_q == OP_DEL || !promote_q) begin
							rsp_valid_q <= 1'b1;
						end
					end else if (s_last) begin
						if (op_q != OP_PUT) begin
							rsp_valid_q <= 1'b1;
						end
					end else begin
						chk_s1 <= 1'b1;
						idx_s1 <= scan_q;
						scan_q <= scan_q + SCW'(1);
					end
				end
				ST_ROOM: begin
					scan_q <= '0;
				end
				ST_LRU: begin
					if (!lru_hit) begin
						scan_q <= scan_q + SCW'(1);
					end
				end
				ST_DRD: begin
					scan_q <= '0;
				end
				ST_SFREE: begin
					if (sfree) begin
						svalid_q[scan_q[SIW-1:0]] <= 1'b1;
					end else if (!s_end) begin
						scan_q <= scan_q + SCW'(1);
					end
				end
				ST_FFREE: begin
					if (ffree) begin
						rsp_valid_q <= 1'b1;
					end else begin
						scan_q <= scan_q + SCW'(1);
					end
				end
				ST_DONE: begin
					if (rsp.ready) begin
						rsp_valid_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					op_q    <= tlkv_op_t'(req.operation);
					key_q   <= req.key[KEY_BITS-1:0];
					val_q   <= req.write_value[VALUE_BITS-1:0];
					found_q <= 1'b0;
					tier_q  <= TIER_MISS;
					rd_q    <= '0;
					ovf_q   <= 1'b0;
				end
			end
			ST_FSCAN: begin
				if (fmatch) begin
					found_q <= 1'b1;
					tier_q  <= TIER_FAST;
					if (op_q == OP_GET) begin
						rd_q <= f_val;
					end
				end
			end
			ST_SSCAN: begin
				if (smatch) begin
					found_q   <= 1'b1;
					tier_q    <= TIER_SLOW;
					ins_mru_q <= 1'b0;
					ins_val_q <= (op_q == OP_PUT) ? val_q : s_val;
					if (op_q == OP_GET) begin
						rd_q <= s_val;
					end
				end else if (s_last) begin
					ins_mru_q <= 1'b1;
					ins_val_q <= val_q;
				end
			end
			ST_LRU: begin
				if (lru_hit) begin
					slot_q <= scan_q[FIW-1:0];
				end
			end
			ST_DRD: begin
				dkey_q <= f_key;
				dval_q <= f_val;
			end
			ST_SFREE: begin
				if (!sfree && s_end) begin
					ovf_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// drive the ports
	assign req.ready          = (state_q == ST_IDLE);
	assign cfg.ready          = 1'b1;
	assign rsp.valid          = rsp_valid_q;
	assign rsp.found          = found_q;
	assign rsp.hit_tier       = tier_q;
	assign rsp.read_value     = FIELD_W'(rd_q);
	assign rsp.fast_hit_total = fast_hits_q;
	assign rsp.slow_hit_total = slow_hits_q;
	assign rsp.slow_overflow  = ovf_q;

`ifndef SYNTHESIS
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(fvalid) == 32'(fcount))
		else $error("fast count disagrees with valid bits");
	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid))
		else $error("request ready while a response is pending");
	a_victim_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRD) |-> fvalid[slot_q])
		else $error("demoting an invalid fast entry");
	a_insert_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FFREE) |-> (fcount < eff_cap))
		else $error("fast insertion without room");
`endif
endmodule
`default_nettype wire
